/* rtl/lfu_pkg.sv */
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared constants and types for the LFU page replacement block.
// ----------------------------------------------------------------------------
package lfu_pkg;

   localparam int MAX_FRAMES = 8;
   localparam int PAGE_COUNT = 64;

   localparam int FRAME_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int NFRAME_W = FRAME_W + 1;
   localparam int PAGE_W   = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;

   localparam int IN_PAGE_W  = 6;
   localparam int OUT_SLOT_W = 3;
   localparam int OUT_PAGE_W = 6;
   localparam int HIT_W      = 16;
   localparam int COUNT_W    = 16;
   localparam int STAMP_W    = 32;
   localparam int NUM_W      = 4;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [NUM_W-1:0] NUM_FRAMES_RESET = NUM_W'(8);

   typedef enum logic [0:0] {
      REG_NUM_FRAMES = 1'b0
   } reg_index_type;

   typedef struct packed {
      logic               act;
      logic [COUNT_W-1:0] count;
      logic [STAMP_W-1:0] stamp;
   } cand_type;

endpackage

/* rtl/lfu_req_if.sv */
// ----------------------------------------------------------------------------
// lfu_req_if
// Page reference channel: valid/ready handshake with one page number.
// ----------------------------------------------------------------------------
interface lfu_req_if;
   logic                         valid;
   logic                         ready;
   logic [lfu_pkg::IN_PAGE_W-1:0] page;

   modport source (output valid, output page, input ready);
   modport sink   (input valid, input page, output ready);
endinterface

/* rtl/lfu_rsp_if.sv */
// ----------------------------------------------------------------------------
// lfu_rsp_if
// Result channel: valid/ready handshake with hit, slot and eviction info.
// ----------------------------------------------------------------------------
interface lfu_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           hit;
   logic [lfu_pkg::OUT_SLOT_W-1:0] slot;
   logic                           evicted_valid;
   logic [lfu_pkg::OUT_PAGE_W-1:0] evicted_page;
   logic [lfu_pkg::HIT_W-1:0]      hit_total;

   modport source (output valid, output hit, output slot, output evicted_valid,
                   output evicted_page, output hit_total, input ready);
   modport sink   (input valid, input hit, input slot, input evicted_valid,
                   input evicted_page, input hit_total, output ready);
endinterface

/* rtl/lfu_victim.sv */
// ----------------------------------------------------------------------------
// lfu_victim
// Min-select tree: least use count, then oldest stamp, then lowest index.
// ----------------------------------------------------------------------------
module lfu_victim (
   input  lfu_pkg::cand_type              cand [lfu_pkg::MAX_FRAMES],
   output logic [lfu_pkg::FRAME_W-1:0]    victim
);

   localparam int LEVELS = lfu_pkg::FRAME_W;
   localparam int LEAVES = 1 << LEVELS;

   lfu_pkg::cand_type          node     [LEVELS+1][LEAVES];
   logic [lfu_pkg::FRAME_W-1:0] node_idx [LEVELS+1][LEAVES];

   always_comb begin
      lfu_pkg::cand_type a;
      lfu_pkg::cand_type b;
      logic              take_b;
      a      = '0;
      b      = '0;
      take_b = 1'b0;
      for (int l = 0; l <= LEVELS; l++) begin
         for (int i = 0; i < LEAVES; i++) begin
            node[l][i]     = '0;
            node_idx[l][i] = '0;
         end
      end
      for (int k = 0; k < LEAVES; k++) begin
         if (k < lfu_pkg::MAX_FRAMES) begin
            node[0][k] = cand[k];
         end
         node_idx[0][k] = lfu_pkg::FRAME_W'(k);
      end
      for (int l = 0; l < LEVELS; l++) begin
         for (int i = 0; i < (LEAVES >> (l + 1)); i++) begin
            a = node[l][2*i];
            b = node[l][2*i+1];
            // lower index wins on a full tie
            take_b = b.act && (!a.act || (b.count < a.count) ||
                     ((b.count == a.count) && (b.stamp < a.stamp)));
            node[l+1][i]     = take_b ? b : a;
            node_idx[l+1][i] = take_b ? node_idx[l][2*i+1] : node_idx[l][2*i];
         end
      end
   end

   assign victim = node_idx[LEVELS][0];

endmodule

/* rtl/lfu_page_replacement.sv */
// ----------------------------------------------------------------------------
// lfu_page_replacement
// LFU page replacement with LRU tie-break over a small resident frame set.
// ----------------------------------------------------------------------------
// Usage:
//   req_port carries one page number per word; rsp_port returns one word per
//   reference: hit, slot holding the page, evicted page if any, hit total.
//   csr_* is an APB-style port; num_frames sits at byte address 0.
// Timing:
//   A reference lands in an input register, the frame match and victim tree
//   run on it combinationally, and the result register is loaded when the
//   input stage advances (result register empty or rsp_port.ready high).
//   One reference per cycle sustained while rsp_port.ready stays high; the limit
//   is the combinational match plus min-select tree over the frames.
// Reset:
//   All frames empty, counts, stamps, reference clock and hit total zero,
//   num_frames = 8.
// Stall:
//   With a result waiting and rsp_port.ready low the result register holds;
//   one more reference may sit in the input register, after which req_port.ready drops.
//   Pages are taken modulo PAGE_COUNT (a power of two).
// ----------------------------------------------------------------------------
module lfu_page_replacement (
   input  logic                              clock,
   input  logic                              reset,
   lfu_req_if.sink                           req_port,
   lfu_rsp_if.source                         rsp_port,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [lfu_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [lfu_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [lfu_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   localparam int MAXF = lfu_pkg::MAX_FRAMES;

   // configuration
   logic [lfu_pkg::NUM_W-1:0] num_frames_ff;
   logic                      csr_hit_reg;
   logic                      csr_wr;

   // input stage
   logic                         s1_valid_ff;
   logic [lfu_pkg::IN_PAGE_W-1:0] s1_page_ff;
   logic                         s1_adv;
   logic                         s1_fire;

   // frame table
   logic                          frame_valid_ff [MAXF];
   logic [lfu_pkg::PAGE_W-1:0]    frame_page_ff  [MAXF];
   logic [lfu_pkg::COUNT_W-1:0]   use_count_ff   [MAXF];
   logic [lfu_pkg::STAMP_W-1:0]   last_use_ff    [MAXF];
   logic [lfu_pkg::STAMP_W-1:0]   ref_clock_ff;
   logic [lfu_pkg::HIT_W-1:0]     hit_cnt_ff;
   logic [lfu_pkg::HIT_W-1:0]     hit_cnt_in;

   // lookup
   logic [lfu_pkg::NFRAME_W-1:0]  n_eff;
   logic [lfu_pkg::PAGE_W-1:0]    pg;
   logic                          active [MAXF];
   logic                          found_any;
   logic [lfu_pkg::FRAME_W-1:0]   found_idx;
   logic                          empty_any;
   logic [lfu_pkg::FRAME_W-1:0]   empty_idx;
   logic [lfu_pkg::FRAME_W-1:0]   victim;
   logic [lfu_pkg::FRAME_W-1:0]   slot;
   lfu_pkg::cand_type             cand [MAXF];

   // result register
   logic                           out_valid_ff;
   logic                           out_hit_ff;
   logic [lfu_pkg::OUT_SLOT_W-1:0] out_slot_ff;
   logic                           out_ev_valid_ff;
   logic [lfu_pkg::OUT_PAGE_W-1:0] out_ev_page_ff;
   logic [lfu_pkg::HIT_W-1:0]      out_hit_total_ff;

   // ------------------------------------------------------------------------
   // CSR port
   // ------------------------------------------------------------------------
   assign csr_hit_reg = (csr_paddr[lfu_pkg::CSR_ADDR_W-1] ==
                         lfu_pkg::REG_NUM_FRAMES);
   assign csr_wr      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready  = 1'b1;
   assign csr_prdata  = csr_hit_reg ? lfu_pkg::CSR_DATA_W'(num_frames_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_frames_ff <= lfu_pkg::NUM_FRAMES_RESET;
      end else if (csr_wr && csr_hit_reg) begin
         num_frames_ff <= csr_pwdata[lfu_pkg::NUM_W-1:0];
      end
   end

   // ------------------------------------------------------------------------
   // Handshake
   // ------------------------------------------------------------------------
   assign s1_adv         = !out_valid_ff || rsp_port.ready;
   assign s1_fire        = s1_valid_ff && s1_adv;
   assign req_port.ready = !s1_valid_ff || s1_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_port.ready) begin
         s1_valid_ff <= req_port.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_port.ready && req_port.valid) begin
         s1_page_ff <= req_port.page;
      end
   end

   // ------------------------------------------------------------------------
   // Lookup
   // ------------------------------------------------------------------------
   always_comb begin
      if (num_frames_ff == '0) begin
         n_eff = lfu_pkg::NFRAME_W'(1);
      end else if (32'(num_frames_ff) > MAXF) begin
         n_eff = lfu_pkg::NFRAME_W'(MAXF);
      end else begin
         n_eff = lfu_pkg::NFRAME_W'(num_frames_ff);
      end
   end

   assign pg = lfu_pkg::PAGE_W'(s1_page_ff);

   always_comb begin
      found_any = 1'b0;
      found_idx = '0;
      empty_any = 1'b0;
      empty_idx = '0;
      for (int k = 0; k < MAXF; k++) begin
         active[k] = (lfu_pkg::NFRAME_W'(k) < n_eff);
         cand[k]   = '{act: active[k], count: use_count_ff[k], stamp: last_use_ff[k]};
         if (active[k] && frame_valid_ff[k] && (frame_page_ff[k] == pg) && !found_any) begin
            found_any = 1'b1;
            found_idx = lfu_pkg::FRAME_W'(k);
         end
         if (active[k] && !frame_valid_ff[k] && !empty_any) begin
            empty_any = 1'b1;
            empty_idx = lfu_pkg::FRAME_W'(k);
         end
      end
   end

   lfu_victim u_victim (
      .cand   (cand),
      .victim (victim)
   );

   assign slot = found_any ? found_idx : (empty_any ? empty_idx : victim);

   assign hit_cnt_in = (found_any && (hit_cnt_ff != '1)) ? hit_cnt_ff + 1'b1 : hit_cnt_ff;

   // ------------------------------------------------------------------------
   // Frame table update
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MAXF; k++) begin
            frame_valid_ff[k] <= 1'b0;
            use_count_ff[k]   <= '0;
            last_use_ff[k]    <= '0;
         end
         ref_clock_ff <= '0;
         hit_cnt_ff   <= '0;
      end else if (s1_fire) begin
         for (int k = 0; k < MAXF; k++) begin
            if (slot == lfu_pkg::FRAME_W'(k)) begin
               last_use_ff[k] <= ref_clock_ff;
               if (found_any) begin
                  if (use_count_ff[k] != '1) begin
                     use_count_ff[k] <= use_count_ff[k] + 1'b1;
                  end
               end else begin
                  frame_valid_ff[k] <= 1'b1;
                  use_count_ff[k]   <= lfu_pkg::COUNT_W'(1);
               end
            end
         end
         if (ref_clock_ff != '1) begin
            ref_clock_ff <= ref_clock_ff + 1'b1;
         end
         hit_cnt_ff <= hit_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && !found_any) begin
         for (int k = 0; k < MAXF; k++) begin
            if (slot == lfu_pkg::FRAME_W'(k)) begin
               frame_page_ff[k] <= pg;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result register
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_fire) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_port.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         out_hit_ff       <= found_any;
         out_slot_ff      <= lfu_pkg::OUT_SLOT_W'(slot);
         out_ev_valid_ff  <= !found_any && !empty_any;
         out_ev_page_ff   <= (!found_any && !empty_any) ?
                             lfu_pkg::OUT_PAGE_W'(frame_page_ff[victim]) : '0;
         out_hit_total_ff <= hit_cnt_in;
      end
   end

   assign rsp_port.valid         = out_valid_ff;
   assign rsp_port.hit           = out_hit_ff;
   assign rsp_port.slot          = out_slot_ff;
   assign rsp_port.evicted_valid = out_ev_valid_ff;
   assign rsp_port.evicted_page  = out_ev_page_ff;
   assign rsp_port.hit_total     = out_hit_total_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   a_hit_total_mono: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (hit_cnt_ff >= $past(hit_cnt_ff)))
      else $error("hit total decreased");

   a_slot_active: assert property (@(posedge clock) disable iff (reset)
      s1_fire |-> ({1'b0, slot} < n_eff))
      else $error("slot outside active frames");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      s1_fire |=> out_valid_ff)
      else $error("result register not loaded");

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && found_any) |=> !out_ev_valid_ff)
      else $error("eviction reported on hit");

endmodule
